// ===== rtl/dbvg_pkg.sv =====
// Shared types and constants of the dual bit-plane video generator.
// Used by the controller, the datapath, the top level and the checker.
package dbvg_pkg;

	localparam int PALETTE_ENTRIES = 32;
	localparam int BANK_BYTES      = 24576;

	localparam int ADDR_W    = 15;
	localparam int OFFS_W    = 13;
	localparam int PAL_IDX_W = $clog2(PALETTE_ENTRIES);
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;

	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_READ     = 2'd1;
	localparam logic [1:0] OP_PAL_LOAD = 2'd2;
	localparam logic [1:0] OP_RENDER   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BANK_SELECT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_SCREEN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A_DISABLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_DISABLE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_HIGH   = 3'd4;

	localparam logic [1:0] PLANE0_BASE = 2'b01;
	localparam logic [1:0] PLANE1_BASE = 2'b00;
	localparam logic [1:0] PLANE2_BASE = 2'b10;

	localparam logic [7:0] WEIGHT_0  = 8'h21;
	localparam logic [7:0] WEIGHT_1  = 8'h47;
	localparam logic [7:0] WEIGHT_2  = 8'h97;
	localparam logic [7:0] WEIGHT_B0 = 8'h4f;
	localparam logic [7:0] WEIGHT_B1 = 8'ha8;

	localparam logic [2:0] LAST_PIXEL = 3'd7;

	typedef enum logic [1:0] {
		RD_SEL_INPUT,
		RD_SEL_PLANE0,
		RD_SEL_PLANE2
	} rd_sel_t;

	typedef struct packed {
		logic        accept;
		rd_sel_t     rd_sel;
		logic        ld_plane1;
		logic        ld_plane0;
		logic        ld_plane2;
		logic        ld_read;
		logic        out_load_read;
		logic        out_load_pix;
		logic [2:0]  pix_idx;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/dbvg_ram.sv =====
// Generic single-port RAM with a registered read.
// Standalone; no package dependency.
module dbvg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/dbvg_ctrl.sv =====
// Controller state machine of the video generator.
// Depends on dbvg_pkg for the command and status types and the op codes.
module dbvg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_op,
	output logic              in_ready,
	input  dbvg_pkg::sts_t    sts,
	output dbvg_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RD_WAIT = 3'd1;
	localparam logic [2:0] ST_RD_OUT  = 3'd2;
	localparam logic [2:0] ST_F0      = 3'd3;
	localparam logic [2:0] ST_F2      = 3'd4;
	localparam logic [2:0] ST_F_LAST  = 3'd5;
	localparam logic [2:0] ST_PIX     = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] pix_cnt_q, pix_cnt_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.rd_sel = dbvg_pkg::RD_SEL_INPUT;
		cmd.pix_idx = pix_cnt_q;
		state_d   = state_q;
		pix_cnt_d = pix_cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					if (in_op == dbvg_pkg::OP_READ) begin
						state_d = ST_RD_WAIT;
					end else if (in_op == dbvg_pkg::OP_RENDER) begin
						state_d = ST_F0;
					end
				end
			end
			ST_RD_WAIT: begin
				cmd.ld_read = 1'b1;
				state_d     = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				if (sts.out_free) begin
					cmd.out_load_read = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_F0: begin
				cmd.ld_plane1 = 1'b1;
				cmd.rd_sel    = dbvg_pkg::RD_SEL_PLANE0;
				state_d       = ST_F2;
			end
			ST_F2: begin
				cmd.ld_plane0 = 1'b1;
				cmd.rd_sel    = dbvg_pkg::RD_SEL_PLANE2;
				state_d       = ST_F_LAST;
			end
			ST_F_LAST: begin
				cmd.ld_plane2 = 1'b1;
				pix_cnt_d     = '0;
				state_d       = ST_PIX;
			end
			ST_PIX: begin
				if (sts.out_free) begin
					cmd.out_load_pix = 1'b1;
					pix_cnt_d        = pix_cnt_q + 3'd1;
					if (pix_cnt_q == dbvg_pkg::LAST_PIXEL) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pix_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			pix_cnt_q <= pix_cnt_d;
		end
	end

endmodule

// ===== rtl/dbvg_datapath.sv =====
// Datapath: bitmap RAMs, palette, configuration, plane buffers and output register.
// Depends on dbvg_pkg and instantiates dbvg_ram for both bitmaps.
module dbvg_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dbvg_pkg::cmd_t                     cmd,
	output dbvg_pkg::sts_t                     sts,
	input  logic [1:0]                         in_op,
	input  logic [dbvg_pkg::IN_DATA_W-1:0]     in_tdata,
	input  logic                               cfg_we,
	input  logic [dbvg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [0:0]                         cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dbvg_pkg::OUT_DATA_W-1:0]    out_tdata,
	output logic                               out_is_pixel,
	output logic                               out_last
);

	logic [dbvg_pkg::ADDR_W-1:0] in_addr;
	logic [7:0]                  in_data;
	logic                        in_bank_ok;
	logic                        in_pal_ok;

	logic bank_q, flip_q, a_dis_q, b_dis_q, color_high_q;

	logic [7:0] palette_q [dbvg_pkg::PALETTE_ENTRIES];

	logic [dbvg_pkg::OFFS_W-1:0] offs_q;
	logic                        rd_ok_q;
	logic [7:0]                  read_q;
	logic [7:0]                  a0_q, a1_q, a2_q, b0_q, b1_q, b2_q;

	logic [dbvg_pkg::ADDR_W-1:0] ram_addr;
	logic                        we_a, we_b;
	logic [7:0]                  rdata_a, rdata_b;

	logic [2:0]                  bit_idx;
	logic [2:0]                  pa, pb;
	logic [4:0]                  color;
	logic [7:0]                  pal_byte;
	logic [7:0]                  red, green, blue;
	logic [7:0]                  x_base, x_pix, y_pix;

	logic                        out_valid_q;
	logic                        out_is_pixel_q;
	logic                        out_last_q;
	logic [7:0]                  out_read_q, out_x_q, out_y_q;
	logic [4:0]                  out_color_q;
	logic [7:0]                  out_red_q, out_green_q, out_blue_q;

	assign in_addr    = in_tdata[14:0];
	assign in_data    = in_tdata[22:15];
	assign in_bank_ok = (in_addr < dbvg_pkg::ADDR_W'(dbvg_pkg::BANK_BYTES));
	assign in_pal_ok  = (in_addr[dbvg_pkg::ADDR_W-1:dbvg_pkg::PAL_IDX_W] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q       <= 1'b0;
			flip_q       <= 1'b0;
			a_dis_q      <= 1'b0;
			b_dis_q      <= 1'b0;
			color_high_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dbvg_pkg::REG_BANK_SELECT: bank_q       <= cfg_data[0];
				dbvg_pkg::REG_FLIP_SCREEN: flip_q       <= cfg_data[0];
				dbvg_pkg::REG_A_DISABLE:   a_dis_q      <= cfg_data[0];
				dbvg_pkg::REG_B_DISABLE:   b_dis_q      <= cfg_data[0];
				dbvg_pkg::REG_COLOR_HIGH:  color_high_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			dbvg_pkg::RD_SEL_PLANE0: ram_addr = {dbvg_pkg::PLANE0_BASE, offs_q};
			dbvg_pkg::RD_SEL_PLANE2: ram_addr = {dbvg_pkg::PLANE2_BASE, offs_q};
			default: begin
				if (in_op == dbvg_pkg::OP_RENDER) begin
					ram_addr = {dbvg_pkg::PLANE1_BASE, in_addr[dbvg_pkg::OFFS_W-1:0]};
				end else begin
					ram_addr = in_addr;
				end
			end
		endcase
	end

	assign we_a = cmd.accept && (in_op == dbvg_pkg::OP_WRITE) && in_bank_ok && !bank_q;
	assign we_b = cmd.accept && (in_op == dbvg_pkg::OP_WRITE) && in_bank_ok && bank_q;

	dbvg_ram #(
		.WIDTH(8),
		.DEPTH(dbvg_pkg::BANK_BYTES)
	) u_bitmap_a (
		.clk  (clk),
		.we   (we_a),
		.addr (ram_addr),
		.wdata(in_data),
		.rdata(rdata_a)
	);

	dbvg_ram #(
		.WIDTH(8),
		.DEPTH(dbvg_pkg::BANK_BYTES)
	) u_bitmap_b (
		.clk  (clk),
		.we   (we_b),
		.addr (ram_addr),
		.wdata(in_data),
		.rdata(rdata_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept && (in_op == dbvg_pkg::OP_PAL_LOAD) && in_pal_ok) begin
			palette_q[in_addr[dbvg_pkg::PAL_IDX_W-1:0]] <= in_data;
		end
		if (cmd.accept) begin
			offs_q  <= in_addr[dbvg_pkg::OFFS_W-1:0];
			rd_ok_q <= in_bank_ok;
		end
		if (cmd.ld_read) begin
			read_q <= rd_ok_q ? (bank_q ? rdata_b : rdata_a) : 8'h00;
		end
		if (cmd.ld_plane1) begin
			a1_q <= rdata_a;
			b1_q <= rdata_b;
		end
		if (cmd.ld_plane0) begin
			a0_q <= rdata_a;
			b0_q <= rdata_b;
		end
		if (cmd.ld_plane2) begin
			a2_q <= rdata_a;
			b2_q <= rdata_b;
		end
	end

	assign bit_idx = dbvg_pkg::LAST_PIXEL - cmd.pix_idx;
	assign pa = a_dis_q ? 3'd0 : {a2_q[bit_idx], a1_q[bit_idx], a0_q[bit_idx]};
	assign pb = b_dis_q ? 3'd0 : {b2_q[bit_idx], b1_q[bit_idx], b0_q[bit_idx]};

	always_comb begin
		if (pa != 3'd0) begin
			color = {color_high_q, 1'b0, pa};
		end else begin
			color = {color_high_q, 1'b1, pb};
		end
	end

	assign pal_byte = palette_q[color];
	assign red   = (pal_byte[0] ? dbvg_pkg::WEIGHT_0 : 8'h00)
		+ (pal_byte[1] ? dbvg_pkg::WEIGHT_1 : 8'h00)
		+ (pal_byte[2] ? dbvg_pkg::WEIGHT_2 : 8'h00);
	assign green = (pal_byte[3] ? dbvg_pkg::WEIGHT_0 : 8'h00)
		+ (pal_byte[4] ? dbvg_pkg::WEIGHT_1 : 8'h00)
		+ (pal_byte[5] ? dbvg_pkg::WEIGHT_2 : 8'h00);
	assign blue  = (pal_byte[6] ? dbvg_pkg::WEIGHT_B0 : 8'h00)
		+ (pal_byte[7] ? dbvg_pkg::WEIGHT_B1 : 8'h00);

	assign x_base = flip_q ? ~{offs_q[4:0], 3'b000} : {offs_q[4:0], 3'b000};
	assign x_pix  = flip_q ? (x_base - {5'd0, cmd.pix_idx}) : (x_base + {5'd0, cmd.pix_idx});
	assign y_pix  = flip_q ? ~offs_q[12:5] : offs_q[12:5];

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_read || cmd.out_load_pix) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_read) begin
			out_is_pixel_q <= 1'b0;
			out_last_q     <= 1'b1;
			out_read_q     <= read_q;
			out_x_q        <= 8'h00;
			out_y_q        <= 8'h00;
			out_color_q    <= 5'd0;
			out_red_q      <= 8'h00;
			out_green_q    <= 8'h00;
			out_blue_q     <= 8'h00;
		end else if (cmd.out_load_pix) begin
			out_is_pixel_q <= 1'b1;
			out_last_q     <= (cmd.pix_idx == dbvg_pkg::LAST_PIXEL);
			out_read_q     <= 8'h00;
			out_x_q        <= x_pix;
			out_y_q        <= y_pix;
			out_color_q    <= color;
			out_red_q      <= red;
			out_green_q    <= green;
			out_blue_q     <= blue;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_is_pixel = out_is_pixel_q;
	assign out_last     = out_last_q;
	assign out_tdata    = {3'b000, out_blue_q, out_green_q, out_red_q, out_color_q,
		out_y_q, out_x_q, out_read_q};

endmodule

// ===== rtl/dual_bitplane_video_generator.sv =====
// Top level of the dual bit-plane video generator.
// Depends on dbvg_pkg; instantiates dbvg_ctrl and dbvg_datapath.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata address,data; tuser op
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata pixel fields; tuser is_pixel
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// Writes and palette loads complete when they are accepted. A read runs RAM read, byte
// capture and output load in that order; the output load waits while the output stalls.
// A render makes three reads of the single RAM port for the planes, captures the last
// plane, then emits eight pixels at one per cycle while the output is not stalled.
// Reset clears the configuration and the control state; RAM contents are undefined.
// A stalled output holds the block; a new request is taken only when the last is done.
module dual_bitplane_video_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// Fields from bit 0: address[14:0], data[22:15], zero pad [23].
	input  logic [dbvg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// Fields from bit 0: op[1:0].
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// Fields from bit 0: read_data[7:0], pixel_x[15:8], pixel_y[23:16],
	// color_index[28:24], red[36:29], green[44:37], blue[52:45], zero pad [55:53].
	output logic [dbvg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// Fields from bit 0: is_pixel[0].
	output logic [0:0]                       m_axis_tuser,
	output logic                             m_axis_tlast,
	input  logic                             cfg_we,
	input  logic [dbvg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [0:0]                       cfg_data
);

	dbvg_pkg::cmd_t cmd;
	dbvg_pkg::sts_t sts;

	dbvg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_op   (s_axis_tuser),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dbvg_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_op       (s_axis_tuser),
		.in_tdata    (s_axis_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_tdata   (m_axis_tdata),
		.out_is_pixel(m_axis_tuser[0]),
		.out_last    (m_axis_tlast)
	);

endmodule

// ===== rtl/dbvg_checker.sv =====
// Port-level checker for the video generator, bound to the top level.
// Depends on dbvg_pkg for widths and op codes.
module dbvg_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [1:0]                       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [dbvg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [0:0]                       m_axis_tuser,
	input logic                             m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled output request changed.");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata[55:8] == '0))
		else $error("Read result is not a single clean request.");

	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == dbvg_pkg::OP_RENDER)
		|=> !s_axis_tready ##1 !s_axis_tready)
		else $error("Input taken during plane fetch.");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == dbvg_pkg::OP_READ)
		|=> !s_axis_tready)
		else $error("Input taken while a read is pending.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[55:53] == 3'b000))
		else $error("Output padding bits are not zero.");

endmodule

bind dual_bitplane_video_generator dbvg_port_checker u_dbvg_port_checker (.*);
